@@ hw/rtl/bpe_pkg.sv @@
// shared types, constants and tables for the bernstein polynomial evaluator
package bpe_pkg;

  localparam int MAX_DEGREE_DEF = 4;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_COEF       = 5;
  localparam int QDEPTH         = 4;

  // register indexes on the configuration port
  localparam logic [2:0] REG_DEGREE = 3'd0;
  localparam logic [2:0] REG_X_LOW  = 3'd1;
  localparam logic [2:0] REG_X_HIGH = 3'd2;
  localparam logic [2:0] REG_COEF0  = 3'd3;
  localparam logic [2:0] REG_COEF1  = 3'd4;
  localparam logic [2:0] REG_COEF2  = 3'd5;
  localparam logic [2:0] REG_COEF3  = 3'd6;
  localparam logic [2:0] REG_COEF4  = 3'd7;

  // binomial coefficients, row n, column i
  localparam logic [2:0] BINOM [NUM_COEF][NUM_COEF] = '{
    '{3'd1, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd1, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd2, 3'd1, 3'd0, 3'd0},
    '{3'd1, 3'd3, 3'd3, 3'd1, 3'd0},
    '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1}
  };

  // configuration as seen by the datapath (degree already clamped)
  typedef struct packed {
    logic [2:0]                  degree;
    logic signed [31:0]          x_low;
    logic signed [31:0]          x_high;
    logic [NUM_COEF-1:0][31:0]   coef;
  } cfg_t;

  // classified sample passed from front to back
  typedef struct packed {
    logic signed [32:0] diff;
    logic               t_zero;
    logic               zs;
  } item_t;

endpackage

@@ hw/rtl/bpe_front.sv @@
// front end: offsets the sample and classifies it against the range
module bpe_front (
  input  bpe_pkg::cfg_t       cfg,
  input  logic signed [31:0]  in_sample,
  output bpe_pkg::item_t      item
);

  logic signed [32:0] diff;
  logic signed [32:0] span;

  assign diff = {in_sample[31], in_sample} - {cfg.x_low[31], cfg.x_low};
  assign span = {cfg.x_high[31], cfg.x_high} - {cfg.x_low[31], cfg.x_low};

  assign item.diff   = diff;
  // at or beyond the low end of the range, whatever the span direction
  assign item.t_zero = (diff == 33'sd0) || (diff[32] != span[32]);
  assign item.zs     = (span == 33'sd0);

endmodule

@@ hw/rtl/bpe_queue.sv @@
// short fifo between front and back
module bpe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bpe_pkg::item_t  push_item,
  input  logic            pop,
  output bpe_pkg::item_t  head,
  output logic            full,
  output logic            empty
);

  localparam int PW = $clog2(bpe_pkg::QDEPTH);
  localparam int CW = $clog2(bpe_pkg::QDEPTH + 1);

  bpe_pkg::item_t mem [bpe_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r, count_nxt;

  assign full  = (count_r == CW'(bpe_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CW'(1);
    else if (!push && pop) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_item;
  end

endmodule

@@ hw/rtl/bpe_integ.sv @@
// free-running pipeline computing the full-range integral from configuration
module bpe_integ #(
  parameter int MAX_DEGREE = bpe_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = bpe_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  bpe_pkg::cfg_t      cfg,
  output logic signed [31:0] integ,
  output logic               integ_sat
);

  localparam int WB = 35;          // quotient bits kept before saturation
  localparam int DS = 5;           // divide stages
  localparam int BPS = WB / DS;    // bits per divide stage

  // stage 1
  logic signed [32:0] span_r;
  logic signed [34:0] csum_r, csum_nxt;
  logic [2:0]         n1_1_r;
  // stage 2
  logic [32:0]        a_r;
  logic [34:0]        b_r;
  logic               neg_2_r;
  logic [2:0]         n1_2_r;
  // stage 3
  logic [51:0]        pl_r;
  logic [50:0]        ph_r;
  logic               neg_3_r;
  logic [2:0]         n1_3_r;
  // stage 4
  logic [67:0]        m_r;
  logic               neg_4_r;
  logic [2:0]         n1_4_r;
  // divide chain
  logic [WB-1:0]      w_r   [DS+1];
  logic [WB-1:0]      q_r   [DS+1];
  logic [2:0]         rem_r [DS+1];
  logic               neg_d_r [DS+1];
  logic               fnz_d_r [DS+1];
  logic               big_d_r [DS+1];
  logic [2:0]         n1_d_r  [DS+1];

  always_comb begin
    csum_nxt = '0;
    for (int i = 0; i <= MAX_DEGREE; i++) begin
      if (3'(i) <= cfg.degree)
        csum_nxt = csum_nxt + 35'(signed'(cfg.coef[i]));
    end
  end

  always_ff @(posedge clk) begin
    span_r  <= {cfg.x_high[31], cfg.x_high} - {cfg.x_low[31], cfg.x_low};
    csum_r  <= csum_nxt;
    n1_1_r  <= cfg.degree + 3'd1;

    a_r     <= span_r[32] ? 33'(-span_r) : 33'(span_r);
    b_r     <= csum_r[34] ? 35'(-csum_r) : 35'(csum_r);
    neg_2_r <= span_r[32] != csum_r[34];
    n1_2_r  <= n1_1_r;

    pl_r    <= 52'(a_r[16:0]) * 52'(b_r);
    ph_r    <= 51'(a_r[32:17]) * 51'(b_r);
    neg_3_r <= neg_2_r;
    n1_3_r  <= n1_2_r;

    m_r     <= {16'd0, pl_r} + {ph_r, 17'd0};
    neg_4_r <= neg_3_r;
    n1_4_r  <= n1_3_r;

    w_r[0]     <= m_r[FRAC_BITS+WB-1:FRAC_BITS];
    q_r[0]     <= '0;
    rem_r[0]   <= '0;
    neg_d_r[0] <= neg_4_r;
    fnz_d_r[0] <= |m_r[FRAC_BITS-1:0];
    big_d_r[0] <= |m_r[67:FRAC_BITS+WB];
    n1_d_r[0]  <= n1_4_r;
  end

  // long division by n+1, a handful of bits per stage
  for (genvar s = 0; s < DS; s++) begin : g_div
    logic [2:0]    rem_c;
    logic [3:0]    rem4;
    logic [WB-1:0] q_c;
    always_comb begin
      rem_c = rem_r[s];
      q_c   = q_r[s];
      rem4  = '0;
      for (int b = 0; b < BPS; b++) begin
        rem4 = {rem_c, w_r[s][WB-1-s*BPS-b]};
        if (rem4 >= {1'b0, n1_d_r[s]}) begin
          rem4 = rem4 - {1'b0, n1_d_r[s]};
          q_c[WB-1-s*BPS-b] = 1'b1;
        end
        rem_c = rem4[2:0];
      end
    end
    always_ff @(posedge clk) begin
      w_r[s+1]     <= w_r[s];
      q_r[s+1]     <= q_c;
      rem_r[s+1]   <= rem_c;
      neg_d_r[s+1] <= neg_d_r[s];
      fnz_d_r[s+1] <= fnz_d_r[s];
      big_d_r[s+1] <= big_d_r[s];
      n1_d_r[s+1]  <= n1_d_r[s];
    end
  end

  logic [WB:0] mag;
  logic        over;

  always_comb begin
    mag  = {1'b0, q_r[DS]} +
           (WB+1)'(neg_d_r[DS] && (rem_r[DS] != 3'd0 || fnz_d_r[DS]));
    over = big_d_r[DS] ||
           (neg_d_r[DS] ? (mag > (WB+1)'(36'h080000000))
                        : (mag > (WB+1)'(36'h07fffffff)));
  end

  always_ff @(posedge clk) begin
    integ_sat <= over;
    if (over) integ <= neg_d_r[DS] ? 32'sh80000000 : 32'sh7fffffff;
    else      integ <= neg_d_r[DS] ? -signed'(mag[31:0]) : signed'(mag[31:0]);
  end

endmodule

@@ hw/rtl/bpe_back.sv @@
// back end: rescale divider, basis products, weighted sum and output register
module bpe_back #(
  parameter int MAX_DEGREE = bpe_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = bpe_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bpe_pkg::cfg_t      cfg,
  input  bpe_pkg::item_t     head,
  input  logic               head_valid,
  output logic               pop,
  input  logic signed [31:0] integ,
  input  logic               integ_sat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_density,
  output logic signed [31:0] out_integral,
  output logic               out_saturated,
  output logic               out_zero_span
);

  localparam int F   = FRAC_BITS;
  localparam int TW  = F + 1;
  localparam int NL  = MAX_DEGREE + 1;
  localparam int TMW = 32 + TW + 4;
  localparam int AW  = TMW + 3;
  localparam logic [TW-1:0] ONE = {1'b1, {F{1'b0}}};
  localparam logic signed [AW-1:0] MAXV = {{(AW-32){1'b0}}, 32'h7fffffff};
  localparam logic signed [AW-1:0] MINV = {{(AW-32){1'b1}}, 32'h80000000};

  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_ready;
  assign pop       = en && head_valid;
  assign out_valid = out_valid_r;

  // magnitude of the span, follows configuration
  logic signed [32:0] span;
  logic [32:0]        abss_r;
  assign span = {cfg.x_high[31], cfg.x_high} - {cfg.x_low[31], cfg.x_low};
  always_ff @(posedge clk) begin
    abss_r <= span[32] ? 33'(-span) : 33'(span);
  end

  // divider pipeline, index 0 is the entry stage
  logic          dv_r  [F+1];
  logic [32:0]   dr_r  [F+1];
  logic [F-1:0]  dq_r  [F+1];
  logic          dcl_r [F+1];
  logic          dtz_r [F+1];
  logic          dzs_r [F+1];
  logic [32:0]   absd;

  assign absd = head.diff[32] ? 33'(-head.diff) : 33'(head.diff);

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (en) dv_r[0] <= head_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dr_r[0]  <= absd;
      dq_r[0]  <= '0;
      dcl_r[0] <= absd >= abss_r;
      dtz_r[0] <= head.t_zero;
      dzs_r[0] <= head.zs;
    end
  end

  for (genvar j = 0; j < F; j++) begin : g_div
    logic [33:0] r2;
    logic        ge;
    logic [33:0] rn;
    assign r2 = {dr_r[j], 1'b0};
    assign ge = r2 >= {1'b0, abss_r};
    assign rn = ge ? r2 - {1'b0, abss_r} : r2;
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[j+1] <= 1'b0;
      else if (en) dv_r[j+1] <= dv_r[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dr_r[j+1]  <= rn[32:0];
        dq_r[j+1]  <= {dq_r[j][F-2:0], ge};
        dcl_r[j+1] <= dcl_r[j];
        dtz_r[j+1] <= dtz_r[j];
        dzs_r[j+1] <= dzs_r[j];
      end
    end
  end

  // t, u and basis products, index 0 holds t and u
  logic          mv_r  [NL];
  logic [TW-1:0] mt_r  [NL];
  logic [TW-1:0] mu_r  [NL];
  logic          mzs_r [NL];
  logic [TW-1:0] mp_r  [NL][NL];
  logic [TW-1:0] t_c;

  always_comb begin
    if (dtz_r[F])      t_c = '0;
    else if (dcl_r[F]) t_c = ONE;
    else               t_c = {1'b0, dq_r[F]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mv_r[0] <= 1'b0;
    else if (en) mv_r[0] <= dv_r[F];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mt_r[0]  <= t_c;
      mu_r[0]  <= ONE - t_c;
      mzs_r[0] <= dzs_r[F];
      for (int i = 0; i < NL; i++) mp_r[0][i] <= ONE;
    end
  end

  for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_mul
    always_ff @(posedge clk) begin
      if (!rst_n) mv_r[k+1] <= 1'b0;
      else if (en) mv_r[k+1] <= mv_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        mt_r[k+1]  <= mt_r[k];
        mu_r[k+1]  <= mu_r[k];
        mzs_r[k+1] <= mzs_r[k];
      end
    end
    for (genvar i = 0; i < NL; i++) begin : g_lane
      logic [TW-1:0]   f;
      logic [2*TW-1:0] prod;
      logic            use_mul;
      assign f       = (k < i) ? mt_r[k] : mu_r[k];
      assign prod    = {{TW{1'b0}}, mp_r[k][i]} * {{TW{1'b0}}, f};
      assign use_mul = (k < i) || (3'(k) < cfg.degree);
      always_ff @(posedge clk) begin
        if (en) mp_r[k+1][i] <= use_mul ? prod[F+TW-1:F] : mp_r[k][i];
      end
    end
  end

  // binomial weighting, coefficient products and sum
  logic                  bv_r, tv_r, sv_r;
  logic                  bzs_r, tzs_r, szs_r;
  logic [TW+2:0]         bp_r   [NL];
  logic signed [TMW-1:0] term_r [NL];
  logic signed [AW-1:0]  acc_r, acc_c;

  always_comb begin
    acc_c = '0;
    for (int i = 0; i < NL; i++) acc_c = acc_c + AW'(term_r[i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= 1'b0;
      tv_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (en) begin
      bv_r <= mv_r[MAX_DEGREE];
      tv_r <= bv_r;
      sv_r <= tv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bzs_r <= mzs_r[MAX_DEGREE];
      tzs_r <= bzs_r;
      szs_r <= tzs_r;
      for (int i = 0; i < NL; i++) begin
        bp_r[i]   <= (TW+3)'(bpe_pkg::BINOM[cfg.degree][i]) *
                     (TW+3)'(mp_r[MAX_DEGREE][i]);
        term_r[i] <= TMW'(signed'(cfg.coef[i])) * TMW'(signed'({1'b0, bp_r[i]}));
      end
      acc_r <= acc_c;
    end
  end

  // floor shift, clip and output register
  logic signed [AW-1:0] sh;
  logic                 dsat;
  logic signed [31:0]   dens;

  always_comb begin
    sh = acc_r >>> F;
    priority if (szs_r) begin
      dens = '0;
      dsat = 1'b0;
    end else if (sh > MAXV) begin
      dens = 32'sh7fffffff;
      dsat = 1'b1;
    end else if (sh < MINV) begin
      dens = 32'sh80000000;
      dsat = 1'b1;
    end else begin
      dens = sh[31:0];
      dsat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= sv_r;
  end

  always_ff @(posedge clk) begin
    if (en && sv_r) begin
      out_density   <= dens;
      out_integral  <= integ;
      out_saturated <= dsat || integ_sat;
      out_zero_span <= szs_r;
    end
  end

endmodule

@@ hw/rtl/bernstein_polynomial_eval.sv @@
// top level of the bernstein polynomial evaluator
// Accepts one signed Q16.16 sample per cycle, rescales it onto the configured
// x range and returns the Bernstein sum of the configured degree together
// with the integral over the whole range; a new beat can be taken every
// cycle for as long as the result side keeps up. The rescale divider produces
// one quotient bit per pipeline stage and is followed by one multiply stage
// per degree of the basis products. A four-entry queue sits between the
// classifying front end and the arithmetic back end, so in_ready only drops
// once that queue is full. The integral depends on configuration alone and
// is formed by a separate free-running pipeline; configuration must be
// written while no beat is in flight.
module bernstein_polynomial_eval #(
  parameter int MAX_DEGREE = bpe_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = bpe_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_density,
  output logic signed [31:0] out_integral,
  output logic               out_saturated,
  output logic               out_zero_span,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  // configuration registers
  logic [2:0]                          degree_r;
  logic signed [31:0]                  x_low_r;
  logic signed [31:0]                  x_high_r;
  logic [bpe_pkg::NUM_COEF-1:0][31:0]  coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= '0;
      x_low_r  <= '0;
      x_high_r <= 32'sd1 <<< FRAC_BITS;
      // weight 0 resets to one, all others to zero
      coef_r   <= (bpe_pkg::NUM_COEF*32)'(32'd1 << FRAC_BITS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpe_pkg::REG_DEGREE: degree_r  <= cfg_wdata[2:0];
        bpe_pkg::REG_X_LOW:  x_low_r   <= signed'(cfg_wdata);
        bpe_pkg::REG_X_HIGH: x_high_r  <= signed'(cfg_wdata);
        bpe_pkg::REG_COEF0:  coef_r[0] <= cfg_wdata;
        bpe_pkg::REG_COEF1:  coef_r[1] <= cfg_wdata;
        bpe_pkg::REG_COEF2:  coef_r[2] <= cfg_wdata;
        bpe_pkg::REG_COEF3:  coef_r[3] <= cfg_wdata;
        bpe_pkg::REG_COEF4:  coef_r[4] <= cfg_wdata;
      endcase
    end
  end

  // degree above the build limit is treated as the limit
  bpe_pkg::cfg_t cfg;
  assign cfg.degree = (degree_r > 3'(MAX_DEGREE)) ? 3'(MAX_DEGREE) : degree_r;
  assign cfg.x_low  = x_low_r;
  assign cfg.x_high = x_high_r;
  assign cfg.coef   = coef_r;

  // front end and queue
  bpe_pkg::item_t front_item, head;
  logic           q_full, q_empty, pop, push;

  bpe_front u_front (
    .cfg       (cfg),
    .in_sample (in_sample),
    .item      (front_item)
  );

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  bpe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // integral over the full range, from configuration only
  logic signed [31:0] integ;
  logic               integ_sat;

  bpe_integ #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_integ (
    .clk       (clk),
    .cfg       (cfg),
    .integ     (integ),
    .integ_sat (integ_sat)
  );

  // back end with the result register
  bpe_back #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .head          (head),
    .head_valid    (!q_empty),
    .pop           (pop),
    .integ         (integ),
    .integ_sat     (integ_sat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_density   (out_density),
    .out_integral  (out_integral),
    .out_saturated (out_saturated),
    .out_zero_span (out_zero_span)
  );

endmodule

@@ hw/rtl/bpe_checker.sv @@
// port-level checks for the bernstein polynomial evaluator, with its bind
module bpe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_density,
  input logic signed [31:0] out_integral,
  input logic               out_saturated,
  input logic               out_zero_span
);

  // no result beat straight after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // zero span gives zero density and integral and no clipping
  a_zero_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_span |->
      out_density == 32'sd0 && out_integral == 32'sd0 && !out_saturated)
    else $error("zero span result not zero");

  // a stalled result beat stays
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_density) && $stable(out_integral) &&
      $stable(out_saturated) && $stable(out_zero_span))
    else $error("result payload changed while stalled");

endmodule

bind bernstein_polynomial_eval bpe_checker u_bpe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_density   (out_density),
  .out_integral  (out_integral),
  .out_saturated (out_saturated),
  .out_zero_span (out_zero_span)
);
